@@ hdl/pvm_pkg.sv @@
`timescale 1ns / 1ps

package pvm_pkg;

    // Widths of the item fields.
    localparam int ID_W     = 4;
    localparam int VIEW_W   = 32;
    localparam int ID_SPACE = 1 << ID_W;

    // Stream widths. The input tdata carries server_id and server_view.
    // The output tdata carries the packed result.
    localparam int S_TDATA_W = 40;
    localparam int RES_W     = VIEW_W + 2 * (ID_W + 1);
    localparam int M_TDATA_W = 48;

    // Command codes carried in the input tuser.
    localparam logic CMD_PING = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [ID_SPACE-1:0] ID_ONE = ID_SPACE'(1);

    // One reply to a ping. view_number sits in the lowest bits.
    typedef struct packed {
        logic [ID_W-1:0]   backup_id;
        logic              backup_valid;
        logic [ID_W-1:0]   primary_id;
        logic              primary_valid;
        logic [VIEW_W-1:0] view_number;
    } t_result;

    // The view number stops at its largest value.
    function automatic logic [VIEW_W-1:0] next_view(input logic [VIEW_W-1:0] v);
        next_view = (v == {VIEW_W{1'b1}}) ? v : v + VIEW_W'(1);
    endfunction

endpackage

@@ hdl/primary_backup_view_manager_top.sv @@
`timescale 1ns / 1ps

// Primary/backup view manager. Each input transaction is either a ping from a
// server (tuser = 0) or a periodic liveness check tick (tuser = 1). A ping may
// create the first view, fill an empty backup once the primary has
// acknowledged the current view, or record that acknowledgment; it marks the
// server alive and always returns one result transaction holding the
// current view. A tick returns nothing: if the primary has acknowledged, it
// promotes the backup over a silent primary, drops a silent backup and takes
// the lowest-numbered idle alive server as the new backup, bumping the view
// on any change; it always clears the alive set. Pings whose id is not below
// SERVER_COUNT change nothing and still get an answer. The view number
// saturates at its largest value. Rate: one transaction per clock cycle,
// sustained. The whole state update of an item settles in the single cycle
// in which it is accepted, so the next item sees it at once. A result
// register plus one skid register on the output hold up to two results.
// Input, ticks included, is refused only while the skid register is full,
// which happens when a ping arrives while the consumer stalls with a result
// already waiting; it is taken again in the cycle after that result leaves.
// An accepted ping's result is registered, in the skid register while one waits.

module primary_backup_view_manager_top #(
    parameter int SERVER_COUNT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave side. tdata: sender id [3:0], server_view [35:4], zero fill.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [pvm_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // tuser: cmd [0].
    input  logic                            i_s_tuser,
    // Master side. tdata: view_number [31:0], primary_valid [32],
    // primary_id [36:33], backup_valid [37], backup_id [41:38], zero fill.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [pvm_pkg::M_TDATA_W-1:0]   o_m_tdata
);

    import pvm_pkg::*;

    // Ping ids are only four bits wide, so no alive bit above that range
    // can ever be set.
    localparam int ALIVE_W = (SERVER_COUNT < ID_SPACE) ? SERVER_COUNT : ID_SPACE;

    // View state.
    logic [ALIVE_W-1:0] r_alive,   n_alive;
    logic [VIEW_W-1:0]  r_view,    n_view;
    logic [ID_W-1:0]    r_primary, n_primary;
    logic               r_pvalid,  n_pvalid;
    logic [ID_W-1:0]    r_backup,  n_backup;
    logic               r_bvalid,  n_bvalid;
    logic               r_ack,     n_ack;

    // Output register and its skid stage.
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    t_result result;

    logic            accept;
    logic            push;
    logic            out_fire;
    logic [ID_W-1:0] s_id;
    logic [VIEW_W-1:0] s_view;

    assign s_id   = i_s_tdata[ID_W-1:0];
    assign s_view = i_s_tdata[ID_W +: VIEW_W];

    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign push       = accept && (i_s_tuser == CMD_PING);
    assign out_fire   = r_out_valid && i_m_tready;

    // Next state for the transaction being accepted in this cycle.
    always_comb begin : p_next
        logic [VIEW_W-1:0]   v;
        logic [ID_W-1:0]     p;
        logic [ID_W-1:0]     b;
        logic                pv;
        logic                bv;
        logic                ack;
        logic                in_range;
        logic                changed;
        logic                idle_found;
        logic [ID_W-1:0]     idle_id;
        logic [ID_SPACE-1:0] alive_all;
        logic [ID_SPACE-1:0] idle_set;

        v          = r_view;
        p          = r_primary;
        b          = r_backup;
        pv         = r_pvalid;
        bv         = r_bvalid;
        ack        = r_ack;
        changed    = 1'b0;
        idle_found = 1'b0;
        idle_id    = '0;
        in_range   = (32'(s_id) < SERVER_COUNT);
        alive_all  = ID_SPACE'(r_alive);
        idle_set   = alive_all
                   & ~(r_pvalid ? (ID_ONE << r_primary) : '0)
                   & ~(r_bvalid ? (ID_ONE << r_backup) : '0);
        n_alive    = r_alive;

        // Lowest idle alive server: scan from the top so the lowest wins.
        for (int i = ID_SPACE - 1; i >= 0; i--) begin
            if (idle_set[i]) begin
                idle_found = 1'b1;
                idle_id    = ID_W'(i);
            end
        end

        if (i_s_tuser == CMD_PING) begin
            if (in_range) begin
                // The very first ping founds view one with this server as primary.
                if (v == '0) begin
                    v  = VIEW_W'(1);
                    p  = s_id;
                    pv = 1'b1;
                    b  = '0;
                    bv = 1'b0;
                end
                if (ack && !(pv && p == s_id) && !bv) begin
                    v  = next_view(v);
                    b  = s_id;
                    bv = 1'b1;
                end
                if (pv && p == s_id && s_view == v) begin
                    ack = 1'b1;
                end
                n_alive = r_alive | ALIVE_W'(ID_ONE << s_id);
            end
        end else begin
            if (r_ack) begin
                // Silent primary: the backup, if any, takes over.
                if (r_pvalid && !alive_all[r_primary]) begin
                    pv      = r_bvalid;
                    p       = r_bvalid ? r_backup : '0;
                    bv      = 1'b0;
                    b       = '0;
                    changed = 1'b1;
                end
                if (bv && !alive_all[b]) begin
                    bv      = 1'b0;
                    b       = '0;
                    changed = 1'b1;
                end
                if (!bv && idle_found) begin
                    bv      = 1'b1;
                    b       = idle_id;
                    changed = 1'b1;
                end
                if (changed) begin
                    v   = next_view(v);
                    ack = 1'b0;
                end else begin
                    p  = r_primary;
                    pv = r_pvalid;
                    b  = r_backup;
                    bv = r_bvalid;
                end
            end
            n_alive = '0;
        end

        n_view    = v;
        n_primary = p;
        n_pvalid  = pv;
        n_backup  = b;
        n_bvalid  = bv;
        n_ack     = ack;

        result.view_number   = v;
        result.primary_valid = pv;
        result.primary_id    = pv ? p : '0;
        result.backup_valid  = bv;
        result.backup_id     = bv ? b : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive   <= '0;
            r_view    <= '0;
            r_primary <= '0;
            r_pvalid  <= 1'b0;
            r_backup  <= '0;
            r_bvalid  <= 1'b0;
            r_ack     <= 1'b0;
        end else if (accept) begin
            r_alive   <= n_alive;
            r_view    <= n_view;
            r_primary <= n_primary;
            r_pvalid  <= n_pvalid;
            r_backup  <= n_backup;
            r_bvalid  <= n_bvalid;
            r_ack     <= n_ack;
        end
    end

    // Output side: the skid entry always holds the younger result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || out_fire) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out);

`ifndef NO_ASSERTIONS
    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without a result in the output register");

    // Primary and backup are never the same server.
    a_distinct_roles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pvalid && r_bvalid) |-> (r_primary != r_backup))
        else $error("primary and backup hold the same server");

    // An acknowledgment can only stand for an existing primary.
    a_ack_needs_primary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ack |-> r_pvalid)
        else $error("acknowledge set with no primary");

    // The view number never moves backward.
    a_view_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_view >= $past(r_view)))
        else $error("view number decreased");
`endif

endmodule

@@ test/tb_primary_backup_view_manager_top.sv @@
`timescale 1ns / 1ps

// Testbench for the primary/backup view manager. A predictor of the view
// state runs in step with every accepted input transaction, and each result
// transaction is compared field by field with the oldest pending prediction.

module tb_primary_backup_view_manager_top;

    import pvm_pkg::*;

    localparam int N_SERVERS    = 16;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_ITEMS = 650;
    localparam int N_OPENING    = 25;

    // One row of the directed opening. When given is set, want is the
    // result that the row must produce; otherwise the predictor decides.
    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [VIEW_W-1:0] sview;
        logic              given;
        t_result           want;
    } t_stim_row;

    // The first ping after reset makes its sender primary in view 1.
    localparam t_result FIRST_VIEW = '{view_number: 32'd1, primary_valid: 1'b1,
                                      primary_id: 4'd15, default: '0};

    localparam t_stim_row OPENING [N_OPENING] = '{
        '{CMD_PING, 4'd15, 32'hFFFF_FFFF, 1'b1, FIRST_VIEW}, // first view, no ack
        '{CMD_PING, 4'd4,  32'd1,         1'b1, FIRST_VIEW}, // no backup before ack
        '{CMD_TICK, 4'd15, 32'hFFFF_FFFF, 1'b0, '0},         // tick without ack
        '{CMD_PING, 4'd15, 32'd1,         1'b0, '0},         // primary acknowledges
        '{CMD_PING, 4'd0,  32'd0,         1'b0, '0},         // fills the backup
        '{CMD_PING, 4'd15, 32'd2,         1'b0, '0},
        '{CMD_TICK, 4'd0,  32'd0,         1'b0, '0},         // both alive, no change
        '{CMD_TICK, 4'd0,  32'd0,         1'b0, '0},         // backup promoted
        '{CMD_PING, 4'd0,  32'd3,         1'b0, '0},
        '{CMD_PING, 4'd5,  32'd0,         1'b0, '0},
        '{CMD_PING, 4'd3,  32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_PING, 4'd9,  32'h5555_5555, 1'b0, '0},
        '{CMD_TICK, 4'd9,  32'd0,         1'b0, '0},
        '{CMD_PING, 4'd0,  32'd4,         1'b0, '0},
        '{CMD_PING, 4'd9,  32'd0,         1'b0, '0},
        '{CMD_PING, 4'd3,  32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_TICK, 4'd0,  32'd0,         1'b0, '0},         // silent backup, idle 3 over 9
        '{CMD_PING, 4'd3,  32'd5,         1'b0, '0},
        '{CMD_TICK, 4'd0,  32'd0,         1'b0, '0},
        '{CMD_PING, 4'd0,  32'd5,         1'b0, '0},
        '{CMD_TICK, 4'd0,  32'd0,         1'b0, '0},         // backup dropped, none idle
        '{CMD_PING, 4'd0,  32'd6,         1'b0, '0},
        '{CMD_PING, 4'd12, 32'd0,         1'b0, '0},
        '{CMD_PING, 4'd1,  32'd0,         1'b0, '0},
        '{CMD_PING, 4'd0,  32'd7,         1'b0, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;  // sender id [3:0], server_view [35:4], zero fill.
    logic                 i_s_tuser;  // cmd [0].
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;  // view_number [31:0], primary_valid [32],
                                      // primary_id [36:33], backup_valid [37],
                                      // backup_id [41:38], zero fill.

    primary_backup_view_manager_top #(
        .SERVER_COUNT(N_SERVERS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    // Predicted view state.
    logic [N_SERVERS-1:0] vs_alive   = '0;
    logic [VIEW_W-1:0]    vs_view    = '0;
    logic [ID_W-1:0]      vs_prim    = '0;
    logic                 vs_prim_ok = 1'b0;
    logic [ID_W-1:0]      vs_back    = '0;
    logic                 vs_back_ok = 1'b0;
    logic                 vs_acked   = 1'b0;

    t_result pending_views[$];

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  checked_count  = 0;
    int  n_pings        = 0;
    int  n_ticks        = 0;
    int  n_changes      = 0;
    int  n_promotions   = 0;
    int  hold_left      = 0;
    bit  steady_flow    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Timeout after %0d cycles, %0d results still pending.",
                 cycle_count, pending_views.size());
        $display("primary_backup_view_manager_top: mismatch");
        $finish;
    end

    function automatic logic [VIEW_W-1:0] sat_inc(input logic [VIEW_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Moves the predicted state over one accepted transaction and returns
    // the reply that a ping produces. A tick produces none.
    task automatic advance_views(input logic cmd, input logic [ID_W-1:0] id,
                                 input logic [VIEW_W-1:0] sview,
                                 output bit replies, output t_result reply);
        logic            idle_ok;
        logic [ID_W-1:0] idle;
        logic            p_ok, b_ok, changed;
        logic [ID_W-1:0] p, b;
        replies = 1'b0;
        reply   = '0;
        if (cmd == CMD_TICK) begin
            n_ticks++;
            if (vs_acked) begin
                // Scan downward so that the lowest idle id wins.
                idle_ok = 1'b0;
                idle    = '0;
                for (int i = N_SERVERS - 1; i >= 0; i--) begin
                    if (vs_alive[i] && !(vs_prim_ok && vs_prim == i) &&
                        !(vs_back_ok && vs_back == i)) begin
                        idle_ok = 1'b1;
                        idle    = ID_W'(i);
                    end
                end
                p_ok    = vs_prim_ok;
                p       = vs_prim;
                b_ok    = vs_back_ok;
                b       = vs_back;
                changed = 1'b0;
                if (p_ok && !vs_alive[p]) begin
                    if (b_ok) n_promotions++;
                    p_ok    = b_ok;
                    p       = b_ok ? b : '0;
                    b_ok    = 1'b0;
                    b       = '0;
                    changed = 1'b1;
                end
                if (b_ok && !vs_alive[b]) begin
                    b_ok    = 1'b0;
                    b       = '0;
                    changed = 1'b1;
                end
                if (!b_ok && idle_ok) begin
                    b_ok    = 1'b1;
                    b       = idle;
                    changed = 1'b1;
                end
                if (changed) begin
                    n_changes++;
                    vs_view    = sat_inc(vs_view);
                    vs_prim_ok = p_ok;
                    vs_prim    = p;
                    vs_back_ok = b_ok;
                    vs_back    = b;
                    vs_acked   = 1'b0;
                end
            end
            vs_alive = '0;
        end else begin
            n_pings++;
            if (id < N_SERVERS) begin
                if (vs_view == '0) begin
                    vs_view    = 1;
                    vs_prim    = id;
                    vs_prim_ok = 1'b1;
                    vs_back    = '0;
                    vs_back_ok = 1'b0;
                end
                if (vs_acked && !(vs_prim_ok && vs_prim == id) && !vs_back_ok) begin
                    vs_view    = sat_inc(vs_view);
                    vs_back    = id;
                    vs_back_ok = 1'b1;
                end
                if (vs_prim_ok && vs_prim == id && sview == vs_view) vs_acked = 1'b1;
                vs_alive[id] = 1'b1;
            end
            replies             = 1'b1;
            reply.view_number   = vs_view;
            reply.primary_valid = vs_prim_ok;
            reply.primary_id    = vs_prim_ok ? vs_prim : '0;
            reply.backup_valid  = vs_back_ok;
            reply.backup_id     = vs_back_ok ? vs_back : '0;
        end
    endtask

    // Offers one transaction, waits for the handshake and then records what
    // the block owes for it.
    task automatic offer_request(input logic cmd, input logic [ID_W-1:0] id,
                                 input logic [VIEW_W-1:0] sview,
                                 input logic given = 1'b0, input t_result want = '0);
        bit      replies;
        t_result reply;
        while (!steady_flow && $urandom_range(99) < 26) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {{(S_TDATA_W - VIEW_W - ID_W){1'b0}}, sview, id};
        do @(posedge i_clk); while (!o_s_tready);
        advance_views(cmd, id, sview, replies, reply);
        if (replies) pending_views = {pending_views, (given ? want : reply)};
    endtask

    task automatic flag_result(input string why, input t_result want,
                               input t_result got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"ERROR cycle %0d, %s: expected view=%0d p=%0b/%0d b=%0b/%0d, ",
                      "got view=%0d p=%0b/%0d b=%0b/%0d"},
                     cycle_count, why, want.view_number, want.primary_valid, want.primary_id,
                     want.backup_valid, want.backup_id, got.view_number, got.primary_valid,
                     got.primary_id, got.backup_valid, got.backup_id);
    endtask

    // Result monitor. Values read right after the edge are those that the
    // block saw at the edge, since all drivers use nonblocking assignments.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[RES_W-1:0];
            if (pending_views.size() == 0) begin
                flag_result("result with nothing pending", '0, got);
            end else begin
                want = pending_views.pop_front();
                checked_count++;
                if (got.view_number !== want.view_number ||
                    got.primary_valid !== want.primary_valid ||
                    got.primary_id !== want.primary_id ||
                    got.backup_valid !== want.backup_valid ||
                    got.backup_id !== want.backup_id)
                    flag_result("wrong result", want, got);
            end
        end
    end

    // Result consumer: random stalls, one long hold-off on request, and no
    // stalls at all while steady_flow is set.
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= steady_flow || ($urandom_range(99) >= 26);
            end
        end
    end

    initial begin
        int              random_sent;
        int              burst;
        int              pick;
        bit              hold_done;
        bit              pause_done;
        logic [ID_W-1:0] id;
        logic [VIEW_W-1:0] sview;

        random_sent = 0;
        hold_done   = 1'b0;
        pause_done  = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= CMD_PING;
        i_s_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (OPENING[r])
            offer_request(OPENING[r].cmd, OPENING[r].id, OPENING[r].sview,
                          OPENING[r].given, OPENING[r].want);

        // Random part, one liveness epoch at a time: a burst of pings, mostly
        // from the primary (usually with the current view) and the backup, then a tick.
        while (random_sent < RANDOM_ITEMS) begin
            burst = $urandom_range(7, 1);
            repeat (burst) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    id    = ID_W'($urandom_range(N_SERVERS - 1));
                    sview = $urandom;
                end else if (pick < 45 && vs_prim_ok) begin
                    id    = vs_prim;
                    sview = ($urandom_range(99) < 85) ? vs_view : VIEW_W'($urandom);
                end else if (pick < 65 && vs_back_ok) begin
                    id    = vs_back;
                    sview = ($urandom_range(3) == 0) ? vs_view : VIEW_W'($urandom);
                end else begin
                    id    = ID_W'($urandom_range(N_SERVERS - 1));
                    sview = $urandom_range(1) ? vs_view : VIEW_W'($urandom);
                end
                offer_request(CMD_PING, id, sview);
                random_sent++;
            end

            // Keep someone able to serve as primary, or the service would
            // lose its primary for good before the random part is over.
            if (vs_prim_ok && !vs_alive[vs_prim] &&
                !(vs_back_ok && vs_alive[vs_back])) begin
                offer_request(CMD_PING, vs_prim, vs_view);
                random_sent++;
            end
            offer_request(CMD_TICK, ID_W'($urandom), VIEW_W'($urandom));
            random_sent++;

            if (!hold_done && random_sent >= 200) begin
                // The consumer stalls long while requests keep coming.
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!pause_done && random_sent >= 400) begin
                // The producer waits until every reply has been taken.
                pause_done = 1'b1;
                i_s_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending_views.size() != 0);
            end
            steady_flow = (random_sent >= 450 && random_sent < 560);
        end
        steady_flow = 1'b0;

        // Closing sequence: the primary acknowledges and outlives its backup,
        // then falls silent with no backup left, so the service ends with no
        // primary; later pings only report that view.
        repeat (3) begin
            if (vs_prim_ok) offer_request(CMD_PING, vs_prim, vs_view);
            offer_request(CMD_TICK, 4'd0, 32'd0);
        end
        offer_request(CMD_TICK, 4'd15, 32'hFFFF_FFFF);
        offer_request(CMD_PING, 4'd15, vs_view);
        offer_request(CMD_PING, 4'd0, 32'hFFFF_FFFF);

        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_views.size() != 0);
        repeat (20) @(posedge i_clk);
        mismatch_count += pending_views.size();

        $display("Covered %0d pings and %0d check ticks; %0d replies compared.",
                 n_pings, n_ticks, checked_count);
        $display("Ticks changed the view %0d times, %0d of them by promoting the backup.",
                 n_changes, n_promotions);
        if (mismatch_count == 0) begin
            $display("primary_backup_view_manager_top: match");
        end else begin
            $display("%0d mismatches in total.", mismatch_count);
            $display("primary_backup_view_manager_top: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/pvm_pkg.sv
hdl/primary_backup_view_manager_top.sv
test/tb_primary_backup_view_manager_top.sv
